### src/pfc_pkg.sv
package pfc_pkg;

	localparam int unsigned SIDE       = 5;
	localparam int unsigned LETTER_W   = 5;
	localparam int unsigned ROW_W      = SIDE * LETTER_W;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = ROW_W;
	localparam int unsigned SLOTS      = 4;

	typedef logic [LETTER_W-1:0] letter_t;
	typedef logic [2:0]          coord_t;
	typedef logic [ROW_W-1:0]    key_row_t;
	typedef key_row_t [SIDE-1:0] key_sq_t;
	typedef logic [2:0]          slot_cnt_t;
	typedef logic [1:0]          slot_idx_t;

	localparam letter_t CODE_X = 5'd23;
	localparam letter_t CODE_J = 5'd9;
	localparam letter_t CODE_I = 5'd8;

	localparam coord_t FIRST_COORD = 3'd0;
	localparam coord_t LAST_COORD  = 3'd4;

	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE,
		REG_KEY_ROW0,
		REG_KEY_ROW1,
		REG_KEY_ROW2,
		REG_KEY_ROW3,
		REG_KEY_ROW4
	} reg_idx_t;

	// One digraph on its way to the square lookup.
	typedef struct packed {
		letter_t a;
		letter_t b;
		logic    dec;
		logic    twice;
	} pair_t;

	typedef struct packed {
		letter_t r0;
		letter_t r1;
	} xres_t;

	function automatic coord_t step_coord(coord_t v, logic dec);
		coord_t n;
		if (dec) begin
			n = (v == FIRST_COORD) ? LAST_COORD : coord_t'(v - 3'd1);
		end else begin
			n = (v == LAST_COORD) ? FIRST_COORD : coord_t'(v + 3'd1);
		end
		return n;
	endfunction

	function automatic letter_t sq_cell(key_sq_t key, coord_t r, coord_t c);
		return key[r][c*LETTER_W +: LETTER_W];
	endfunction

endpackage

### src/pfc_front.sv
module pfc_front import pfc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    mode,
	input  logic    in_valid,
	output logic    in_stall,
	input  letter_t letter_in,
	input  logic    message_end,
	input  logic    s1_take,
	output logic    s1_valid,
	output pair_t   s1_pair
);

	letter_t held_letter_q;
	logic    held_valid_q;
	logic    s1_valid_s1;
	pair_t   pair_s1;

	logic    accept;
	letter_t c_f;
	logic    emit;
	pair_t   pair_d;
	logic    hold_d;
	logic    keep_held;

	assign in_stall = s1_valid_s1 && !s1_take;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		c_f       = (mode == MODE_ENC && letter_in == CODE_J) ? CODE_I : letter_in;
		emit      = 1'b0;
		hold_d    = 1'b0;
		keep_held = 1'b0;
		pair_d.a     = held_letter_q;
		pair_d.b     = c_f;
		pair_d.dec   = mode;
		pair_d.twice = 1'b0;
		if (mode == MODE_ENC) begin
			if (!held_valid_q) begin
				if (message_end) begin
					emit     = 1'b1;
					pair_d.a = c_f;
					pair_d.b = CODE_X;
				end else begin
					hold_d = 1'b1;
				end
			end else if (held_letter_q == c_f) begin
				// A doubled letter is split with x; at message end the second
				// copy is padded with x as well, which gives the same digraph.
				emit         = 1'b1;
				pair_d.b     = CODE_X;
				pair_d.twice = message_end;
				keep_held    = !message_end;
			end else begin
				emit = 1'b1;
			end
		end else begin
			if (held_valid_q) begin
				emit = 1'b1;
			end else if (!message_end) begin
				hold_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			s1_valid_s1  <= 1'b0;
		end else begin
			if (accept) begin
				held_valid_q <= hold_d || keep_held;
				s1_valid_s1  <= emit;
			end else if (s1_take) begin
				s1_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold_d) begin
			held_letter_q <= c_f;
		end
		if (accept && emit) begin
			pair_s1 <= pair_d;
		end
	end

	assign s1_valid = s1_valid_s1;
	assign s1_pair  = pair_s1;

endmodule

### src/pfc_xform.sv
module pfc_xform import pfc_pkg::*; (
	input  key_sq_t key,
	input  pair_t   pair,
	output xres_t   res
);

	coord_t r1, c1, r2, c2;

	// Every cell is compared at once; the last match in row-major order wins.
	always_comb begin
		r1 = FIRST_COORD;
		c1 = FIRST_COORD;
		r2 = FIRST_COORD;
		c2 = FIRST_COORD;
		for (int i = 0; i < SIDE; i++) begin
			for (int k = 0; k < SIDE; k++) begin
				if (key[i][k*LETTER_W +: LETTER_W] == pair.a) begin
					r1 = coord_t'(i);
					c1 = coord_t'(k);
				end
				if (key[i][k*LETTER_W +: LETTER_W] == pair.b) begin
					r2 = coord_t'(i);
					c2 = coord_t'(k);
				end
			end
		end
	end

	always_comb begin
		if (r1 == r2) begin
			res.r0 = sq_cell(key, r1, step_coord(c1, pair.dec));
			res.r1 = sq_cell(key, r2, step_coord(c2, pair.dec));
		end else if (c1 == c2) begin
			res.r0 = sq_cell(key, step_coord(r1, pair.dec), c1);
			res.r1 = sq_cell(key, step_coord(r2, pair.dec), c2);
		end else begin
			res.r0 = sq_cell(key, r1, c2);
			res.r1 = sq_cell(key, r2, c1);
		end
	end

endmodule

### src/pfc_emit.sv
module pfc_emit import pfc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  key_sq_t key,
	input  logic    s1_valid,
	input  pair_t   s1_pair,
	output logic    s1_take,
	output logic    out_valid,
	input  logic    out_stall,
	output letter_t letter_out,
	output logic    run_last
);

	letter_t [SLOTS-1:0] ob_let_q;
	slot_cnt_t           ob_rem_q;
	slot_idx_t           ob_idx_q;

	xres_t               xr;
	letter_t [SLOTS-1:0] ld_let;
	slot_cnt_t           ld_cnt;
	logic                keep0, keep1;
	logic                fire, ob_free;

	pfc_xform u_xform (
		.key  (key),
		.pair (s1_pair),
		.res  (xr)
	);

	always_comb begin
		keep0 = !s1_pair.dec || xr.r0 != CODE_X;
		keep1 = !s1_pair.dec || xr.r1 != CODE_X;
		ld_let[0] = xr.r0;
		ld_let[1] = xr.r1;
		ld_let[2] = xr.r0;
		ld_let[3] = xr.r1;
		if (!s1_pair.dec) begin
			ld_cnt = s1_pair.twice ? 3'd4 : 3'd2;
		end else begin
			unique case ({keep0, keep1})
				2'b11: ld_cnt = 3'd2;
				2'b10: ld_cnt = 3'd1;
				2'b01: begin
					ld_cnt    = 3'd1;
					ld_let[0] = xr.r1;
				end
				default: ld_cnt = 3'd0;
			endcase
		end
	end

	assign out_valid = ob_rem_q != 3'd0;
	assign fire      = out_valid && !out_stall;
	// The buffer can take a new digraph once its final beat leaves.
	assign ob_free   = ob_rem_q == 3'd0 || (ob_rem_q == 3'd1 && !out_stall);
	assign s1_take   = s1_valid && ob_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_rem_q <= 3'd0;
			ob_idx_q <= 2'd0;
		end else if (s1_take) begin
			ob_rem_q <= ld_cnt;
			ob_idx_q <= 2'd0;
		end else if (fire) begin
			ob_rem_q <= ob_rem_q - 3'd1;
			ob_idx_q <= ob_idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			ob_let_q <= ld_let;
		end
	end

	assign letter_out = ob_let_q[ob_idx_q];
	assign run_last   = ob_rem_q == 3'd1;

endmodule

### src/playfair_cipher_stream.sv
// Playfair cipher on a stream of letter codes (a=0 .. z=25) against a 5x5 key
// square loaded through the configuration port as five rows of five 5-bit
// codes. An input beat is taken every cycle while the digraph register ahead
// of the output buffer is free; letters that only open a digraph, trailing odd
// ciphertext letters and decrypted x-x pairs produce no output beat. Each
// completed digraph is looked up in the square as it is loaded into the output
// buffer and then leaves it at one beat per cycle while out_stall is low: two
// beats normally, four for a doubled letter at message end in encrypt mode,
// zero to two in decrypt mode, where every x is dropped. The output port, at
// one beat per cycle, sets the sustained rate, so ordinary text, at about one
// beat per letter, runs near one letter per cycle. run_last marks the final
// beat caused by one input letter. Change the mode or the square only while the
// block is idle.
module playfair_cipher_stream import pfc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [4:0]            letter_in,
	input  logic                  message_end,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [4:0]            letter_out,
	output logic                  run_last
);

	logic    mode_q;
	key_sq_t key_q;
	logic    s1_valid;
	pair_t   s1_pair;
	logic    s1_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENC;
			key_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:     mode_q   <= cfg_data[0];
				REG_KEY_ROW0: key_q[0] <= cfg_data;
				REG_KEY_ROW1: key_q[1] <= cfg_data;
				REG_KEY_ROW2: key_q[2] <= cfg_data;
				REG_KEY_ROW3: key_q[3] <= cfg_data;
				REG_KEY_ROW4: key_q[4] <= cfg_data;
				default: ;
			endcase
		end
	end

	pfc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.letter_in   (letter_in),
		.message_end (message_end),
		.s1_take     (s1_take),
		.s1_valid    (s1_valid),
		.s1_pair     (s1_pair)
	);

	pfc_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.key        (key_q),
		.s1_valid   (s1_valid),
		.s1_pair    (s1_pair),
		.s1_take    (s1_take),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.letter_out (letter_out),
		.run_last   (run_last)
	);

endmodule

### tb/sv/playfair_cipher_stream_tb.sv
module playfair_cipher_stream_tb;
	import pfc_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 16;
	localparam int CYCLE_LIMIT   = 200000;

	typedef enum logic [1:0] {JOB_LETTER, JOB_CFG, JOB_DRAIN, JOB_PHASE} job_kind_t;

	typedef struct {
		job_kind_t kind;
		letter_t   letter;
		logic      fin;
		reg_idx_t  idx;
		key_row_t  data;
		int        send_pct;
		int        recv_pct;
	} job_t;

	typedef struct packed {
		letter_t letter;
		logic    run_last;
	} beat_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic [4:0]            letter_in   = '0;
	logic                  message_end = 1'b0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [4:0]            letter_out;
	logic                  run_last;

	// Predictor state, starting from the reset values.
	key_sq_t square  = '0;
	logic    mode_q  = MODE_ENC;
	letter_t held_q  = '0;
	logic    held_ok = 1'b0;

	job_t  stim_q[$];
	beat_t cipher_beats_q[$];

	int send_idle  = 0;
	int recv_idle  = 0;
	int quiet      = 0;
	int fail_count = 0;
	int cycles     = 0;

	playfair_cipher_stream dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.letter_in  (letter_in),
		.message_end(message_end),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.letter_out (letter_out),
		.run_last   (run_last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic letter_t square_at(input key_sq_t sq, input int r, input int c);
		return sq[r][c*LETTER_W +: LETTER_W];
	endfunction

	// Where a letter sits more than once, the last hit in row-major order wins;
	// an absent letter is taken to sit at the top left corner.
	function automatic void find_letter(input key_sq_t sq, input letter_t v,
			output int r, output int c);
		r = 0;
		c = 0;
		for (int i = 0; i < SIDE; i++)
			for (int k = 0; k < SIDE; k++)
				if (square_at(sq, i, k) == v) begin
					r = i;
					c = k;
				end
	endfunction

	function automatic void square_digraph(input key_sq_t sq, input letter_t a,
			input letter_t b, input logic back, output letter_t p, output letter_t q);
		int r1, c1, r2, c2, stp;
		stp = back ? SIDE - 1 : 1;
		find_letter(sq, a, r1, c1);
		find_letter(sq, b, r2, c2);
		if (r1 == r2) begin
			p = square_at(sq, r1, (c1 + stp) % SIDE);
			q = square_at(sq, r2, (c2 + stp) % SIDE);
		end else if (c1 == c2) begin
			p = square_at(sq, (r1 + stp) % SIDE, c1);
			q = square_at(sq, (r2 + stp) % SIDE, c2);
		end else begin
			p = square_at(sq, r1, c2);
			q = square_at(sq, r2, c1);
		end
	endfunction

	function automatic void apply_register(input reg_idx_t idx, input key_row_t data);
		case (idx)
			REG_MODE:     mode_q = data[0];
			REG_KEY_ROW0: square[0] = data;
			REG_KEY_ROW1: square[1] = data;
			REG_KEY_ROW2: square[2] = data;
			REG_KEY_ROW3: square[3] = data;
			REG_KEY_ROW4: square[4] = data;
			default: ;
		endcase
	endfunction

	task automatic predict_cipher_beats(input letter_t code, input logic fin);
		letter_t outs[4];
		letter_t p, q, c;
		int n;
		n = 0;
		c = code;
		if (mode_q == MODE_ENC) begin
			if (c == CODE_J)
				c = CODE_I;
			if (!held_ok) begin
				if (fin) begin
					square_digraph(square, c, CODE_X, 1'b0, outs[0], outs[1]);
					n = 2;
				end else begin
					held_q  = c;
					held_ok = 1'b1;
				end
			end else if (held_q == c) begin
				// A doubled letter is split with x; at message end the second
				// copy is padded as well.
				square_digraph(square, held_q, CODE_X, 1'b0, outs[0], outs[1]);
				n = 2;
				if (fin) begin
					square_digraph(square, c, CODE_X, 1'b0, outs[2], outs[3]);
					n = 4;
				end
			end else begin
				square_digraph(square, held_q, c, 1'b0, outs[0], outs[1]);
				n = 2;
				held_ok = 1'b0;
			end
		end else begin
			if (held_ok) begin
				square_digraph(square, held_q, c, 1'b1, p, q);
				if (p != CODE_X) begin
					outs[n] = p;
					n++;
				end
				if (q != CODE_X) begin
					outs[n] = q;
					n++;
				end
				held_ok = 1'b0;
			end else if (!fin) begin
				held_q  = c;
				held_ok = 1'b1;
			end
		end
		if (fin)
			held_ok = 1'b0;
		for (int k = 0; k < n; k++)
			cipher_beats_q.push_back('{letter: outs[k], run_last: (k == n - 1)});
	endtask

	task automatic add_letter(input letter_t v, input logic fin);
		stim_q.push_back('{kind: JOB_LETTER, letter: v, fin: fin, idx: REG_MODE,
			data: '0, send_pct: 0, recv_pct: 0});
	endtask

	task automatic add_text(input string s, input logic fin);
		for (int i = 0; i < s.len(); i++)
			add_letter(letter_t'(s[i] - "a"), fin && (i == s.len() - 1));
	endtask

	task automatic add_cfg(input reg_idx_t idx, input key_row_t data);
		stim_q.push_back('{kind: JOB_CFG, letter: '0, fin: 1'b0, idx: idx,
			data: data, send_pct: 0, recv_pct: 0});
	endtask

	task automatic add_drain();
		stim_q.push_back('{kind: JOB_DRAIN, letter: '0, fin: 1'b0, idx: REG_MODE,
			data: '0, send_pct: 0, recv_pct: 0});
	endtask

	task automatic add_phase(input int s, input int r);
		stim_q.push_back('{kind: JOB_PHASE, letter: '0, fin: 1'b0, idx: REG_MODE,
			data: '0, send_pct: s, recv_pct: r});
	endtask

	task automatic load_square(input key_sq_t sq, input logic dec);
		// The mode register only looks at bit 0, so the upper bits carry noise.
		add_cfg(REG_MODE, key_row_t'({$urandom(), dec}));
		for (int r = 0; r < SIDE; r++)
			add_cfg(reg_idx_t'(int'(REG_KEY_ROW0) + r), sq[r]);
	endtask

	function automatic key_sq_t shuffled_square();
		letter_t pool[25];
		letter_t t;
		int n, k;
		key_sq_t sq;
		n = 0;
		for (int v = 0; v < 26; v++)
			if (v != CODE_J) begin
				pool[n] = letter_t'(v);
				n++;
			end
		for (int i = 24; i > 0; i--) begin
			k       = $urandom_range(i);
			t       = pool[i];
			pool[i] = pool[k];
			pool[k] = t;
		end
		for (int i = 0; i < 25; i++)
			sq[i/SIDE][(i%SIDE)*LETTER_W +: LETTER_W] = pool[i];
		return sq;
	endfunction

	// In decrypt mode most of the text is real ciphertext of random plaintext,
	// so that x drops and x-x pairs turn up; the rest is loose letters that
	// knock the pairing out of step.
	task automatic add_random_text(input key_sq_t sq, input logic dec, input int count);
		letter_t a, b, p, q, prev;
		int left;
		left = count;
		prev = letter_t'($urandom_range(25));
		while (left > 0) begin
			if (dec && $urandom_range(3) != 0) begin
				if ($urandom_range(19) == 0) begin
					a = CODE_X;
					b = CODE_X;
				end else begin
					a = letter_t'($urandom_range(25));
					b = ($urandom_range(3) == 0) ? CODE_X : letter_t'($urandom_range(25));
				end
				square_digraph(sq, a, b, 1'b0, p, q);
				add_letter(p, 1'b0);
				add_letter(q, $urandom_range(7) == 0);
				left -= 2;
			end else begin
				if ($urandom_range(19) == 0)
					a = letter_t'($urandom_range(31, 26));
				else if (!dec && $urandom_range(4) == 0)
					a = prev;
				else
					a = letter_t'($urandom_range(25));
				add_letter(a, $urandom_range(7) == 0);
				prev = a;
				left--;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic next_valid;
		logic next_we;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_we   <= 1'b0;
		end else begin
			next_valid = in_valid;
			next_we    = 1'b0;
			if (in_valid && !in_stall) begin
				predict_cipher_beats(letter_in, message_end);
				next_valid = 1'b0;
				quiet      = 0;
			end else if (in_valid || cipher_beats_q.size() != 0) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (!next_valid && stim_q.size() != 0) begin
				case (stim_q[0].kind)
					JOB_LETTER: begin
						if ($urandom_range(99) >= send_idle) begin
							letter_in   <= stim_q[0].letter;
							message_end <= stim_q[0].fin;
							next_valid = 1'b1;
							void'(stim_q.pop_front());
						end
					end
					JOB_CFG: begin
						// A letter that caused no beat may still be in flight, so the write
						// waits until the quiet counter reaches SETTLE_CYCLES.
						if (quiet >= SETTLE_CYCLES) begin
							cfg_index <= stim_q[0].idx;
							cfg_data  <= stim_q[0].data;
							next_we = 1'b1;
							apply_register(stim_q[0].idx, stim_q[0].data);
							void'(stim_q.pop_front());
						end
					end
					JOB_DRAIN: begin
						if (cipher_beats_q.size() == 0)
							void'(stim_q.pop_front());
					end
					default: begin
						send_idle = stim_q[0].send_pct;
						recv_idle = stim_q[0].recv_pct;
						void'(stim_q.pop_front());
					end
				endcase
			end
			in_valid <= next_valid;
			cfg_we   <= next_we;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		beat_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (cipher_beats_q.size() == 0) begin
					$error("unexpected beat: letter_out %0d run_last %0b", letter_out, run_last);
					fail_count++;
				end else begin
					want = cipher_beats_q.pop_front();
					if (letter_out !== want.letter) begin
						$error("letter_out: expected %0d, got %0d", want.letter, letter_out);
						fail_count++;
					end
					if (run_last !== want.run_last) begin
						$error("run_last: expected %0b, got %0b", want.run_last, run_last);
						fail_count++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("playfair_cipher_stream: mismatch");
			$finish;
		end
	end

	initial begin
		key_sq_t sq;
		string   kw;
		int      kind;
		logic    dec;

		// Directed part on a textbook square, encrypt first.
		kw = "playfirexmbcdghknoqstuvwz";
		for (int i = 0; i < 25; i++)
			sq[i/SIDE][(i%SIDE)*LETTER_W +: LETTER_W] = letter_t'(kw[i] - "a");
		add_phase(10, 65);
		load_square(sq, MODE_ENC);
		add_text("dh", 1'b0);
		add_text("hz", 1'b0);
		add_text("as", 1'b0);
		add_text("jk", 1'b0);
		add_text("xxy", 1'b1);
		add_text("oo", 1'b1);
		add_text("f", 1'b1);
		add_letter(letter_t'(31), 1'b1);
		// Switch to decrypt with a letter still held.
		add_text("m", 1'b0);
		add_cfg(REG_MODE, key_row_t'(MODE_DEC));
		add_text("c", 1'b0);
		add_text("me", 1'b0);
		add_text("mm", 1'b0);
		add_text("t", 1'b1);
		add_text("ja", 1'b0);
		add_letter(letter_t'(26), 1'b0);
		add_letter(letter_t'(30), 1'b1);

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: add_phase(10, 65);
				1: add_phase(65, 10);
				default: add_phase(0, 0);
			endcase
			for (int seg = 0; seg < 3; seg++) begin
				kind = ph * 3 + seg;
				dec  = kind[0];
				if (kind == 2) begin
					sq = '0;
				end else if (kind == 5) begin
					sq = '1;
				end else if (kind == 4 || kind == 7) begin
					for (int r = 0; r < SIDE; r++)
						sq[r] = key_row_t'($urandom());
				end else begin
					sq = shuffled_square();
				end
				load_square(sq, dec);
				add_random_text(sq, dec, 26);
				add_drain();
				add_random_text(sq, dec, 26);
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (stim_q.size() != 0 || in_valid)
			@(posedge clk);
		while (cipher_beats_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("playfair_cipher_stream: match");
		else
			$display("playfair_cipher_stream: mismatch");
		$finish;
	end

endmodule

### sim.f
src/pfc_pkg.sv
src/pfc_front.sv
src/pfc_xform.sv
src/pfc_emit.sv
src/playfair_cipher_stream.sv
tb/sv/playfair_cipher_stream_tb.sv
